FILE: rtl/boxds_pkg.sv
// ----------------------------------------------------------------------------
// boxds_pkg
// Shared types and constants for the 2x2 box-average downscaler.
// ----------------------------------------------------------------------------
package boxds_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 4096;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int COLS_REG_W = 11;
    localparam int ROWS_REG_W = 13;
    localparam int RESET_COLS = 1024;
    localparam int RESET_ROWS = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_COLS = 1'b0,
        REG_IMAGE_ROWS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    // horizontal pair sum, 9 bits per channel
    typedef struct packed {
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } t_psum;

    typedef struct packed {
        logic row_last;
        logic frame_last;
    } t_flags;

endpackage

FILE: rtl/boxds_line_buf.sv
// ----------------------------------------------------------------------------
// boxds_line_buf
// Line store of horizontal pair sums: one write and one registered read port.
// ----------------------------------------------------------------------------
module boxds_line_buf #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  boxds_pkg::t_psum      i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output boxds_pkg::t_psum      o_rd_data
);
    import boxds_pkg::*;

    t_psum r_mem [DEPTH];
    t_psum r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/box_average_downscale_2x2_core.sv
// ----------------------------------------------------------------------------
// box_average_downscale_2x2_core
// 2x2 box-filter downsampler for a row-major RGB pixel stream.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------
//   pixel in | in        | i_in_valid / o_in_ready    | i_red, i_green, i_blue
//   pixel out| out       | o_out_valid / i_out_ready  | o_out_red/green/blue,
//            |           |                            | o_row_last, o_frame_last
//   config   | in        | i_cfg_we                   | i_cfg_index, i_cfg_wdata
//
// One pixel per cycle sustained while the output is not stalled. A result is
// built once the odd-row, odd-column pixel completes its block: the line store
// read and middle stage load together, then the add fills the output register.
// Reset is synchronous; the line store is not cleared (odd rows only read
// entries written on the even row before). A config write restarts the frame.
// A stalled output holds the output register; input keeps flowing while the
// middle stage is free or moving.
// ----------------------------------------------------------------------------
module box_average_downscale_2x2_core #(
    parameter int MAX_COLS = boxds_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = boxds_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [boxds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [boxds_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_blue,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_out_red,
    output logic [7:0]                        o_out_green,
    output logic [7:0]                        o_out_blue,
    output logic                              o_row_last,
    output logic                              o_frame_last
);
    import boxds_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_COLS / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RST_COLS = (MAX_COLS < RESET_COLS) ? MAX_COLS : RESET_COLS;
    localparam int RST_ROWS = (MAX_ROWS < RESET_ROWS) ? MAX_ROWS : RESET_ROWS;

    // frame geometry, clamped at write time
    logic [CCW-1:0] r_cols, n_cols;
    logic [RCW-1:0] r_rows, n_rows;
    logic [CW-1:0]  r_col,  n_col;
    logic [RW-1:0]  r_row,  n_row;
    t_pix           r_hold, n_hold;

    logic           r_s1_valid, n_s1_valid;
    t_psum          r_s1_sum,   n_s1_sum;
    t_flags         r_s1_flags, n_s1_flags;

    logic           r_out_valid, n_out_valid;
    t_pix           r_out_pix,   n_out_pix;
    t_flags         r_out_flags, n_out_flags;

    logic           accept;
    logic           out_en;
    logic           s1_en;
    logic           wr_en;
    logic           rd_en;
    logic [AW-1:0]  slot;
    t_psum          pair_sum;
    t_psum          line_sum;
    t_flags         flags;
    logic           col_wrap;
    logic           row_wrap;
    logic [9:0]     tot_r, tot_g, tot_b;
    logic [10:0]    cols_val;
    logic [12:0]    rows_val;

    assign out_en     = !r_out_valid || i_out_ready;
    assign s1_en      = !r_s1_valid || out_en;
    assign o_in_ready = s1_en;
    assign accept     = i_in_valid && s1_en;

    assign pair_sum.red   = {1'b0, r_hold.red}   + {1'b0, i_red};
    assign pair_sum.green = {1'b0, r_hold.green} + {1'b0, i_green};
    assign pair_sum.blue  = {1'b0, r_hold.blue}  + {1'b0, i_blue};

    assign slot  = AW'(r_col >> 1);
    assign wr_en = accept && r_col[0] && !r_row[0];
    assign rd_en = accept && r_col[0] && r_row[0];

    assign col_wrap = ((CW+2)'(r_col) + (CW+2)'(1)) >= (CW+2)'(r_cols);
    assign row_wrap = ((RW+2)'(r_row) + (RW+2)'(1)) >= (RW+2)'(r_rows);
    assign flags.row_last   = ((CW+2)'(r_col) + (CW+2)'(2)) >= (CW+2)'(r_cols);
    assign flags.frame_last = flags.row_last &&
                              (((RW+2)'(r_row) + (RW+2)'(2)) >= (RW+2)'(r_rows));

    boxds_line_buf #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot),
        .i_wr_data (pair_sum),
        .i_rd_en   (rd_en),
        .i_rd_addr (slot),
        .o_rd_data (line_sum)
    );

    // config: clamp to 1..MAX
    assign cols_val = i_cfg_wdata[COLS_REG_W-1:0];
    assign rows_val = i_cfg_wdata[ROWS_REG_W-1:0];

    always_comb begin
        n_cols = r_cols;
        n_rows = r_rows;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_COLS: begin
                    if (cols_val == '0) begin
                        n_cols = CCW'(1);
                    end else if (32'(cols_val) > 32'(MAX_COLS)) begin
                        n_cols = CCW'(MAX_COLS);
                    end else begin
                        n_cols = CCW'(cols_val);
                    end
                end
                REG_IMAGE_ROWS: begin
                    if (rows_val == '0) begin
                        n_rows = RCW'(1);
                    end else if (32'(rows_val) > 32'(MAX_ROWS)) begin
                        n_rows = RCW'(MAX_ROWS);
                    end else begin
                        n_rows = RCW'(rows_val);
                    end
                end
                default: begin
                    n_cols = r_cols;
                end
            endcase
        end
    end

    // position counters and even-column hold
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_hold = r_hold;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (!r_col[0]) begin
                n_hold = '{blue: i_blue, green: i_green, red: i_red};
            end
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // middle stage waits on the line store read
    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_sum   = r_s1_sum;
        n_s1_flags = r_s1_flags;
        if (s1_en) begin
            n_s1_valid = rd_en;
            if (rd_en) begin
                n_s1_sum   = pair_sum;
                n_s1_flags = flags;
            end
        end
    end

    assign tot_r = {1'b0, r_s1_sum.red}   + {1'b0, line_sum.red};
    assign tot_g = {1'b0, r_s1_sum.green} + {1'b0, line_sum.green};
    assign tot_b = {1'b0, r_s1_sum.blue}  + {1'b0, line_sum.blue};

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_pix   = r_out_pix;
        n_out_flags = r_out_flags;
        if (out_en) begin
            n_out_valid = r_s1_valid;
            if (r_s1_valid) begin
                n_out_pix   = '{blue: tot_b[9:2], green: tot_g[9:2], red: tot_r[9:2]};
                n_out_flags = r_s1_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= CCW'(RST_COLS);
            r_rows      <= RCW'(RST_ROWS);
            r_col       <= '0;
            r_row       <= '0;
            r_hold      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cols      <= n_cols;
            r_rows      <= n_rows;
            r_col       <= n_col;
            r_row       <= n_row;
            r_hold      <= n_hold;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sum    <= n_s1_sum;
        r_s1_flags  <= n_s1_flags;
        r_out_pix   <= n_out_pix;
        r_out_flags <= n_out_flags;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_pix.red;
    assign o_out_green  = r_out_pix.green;
    assign o_out_blue   = r_out_pix.blue;
    assign o_row_last   = r_out_flags.row_last;
    assign o_frame_last = r_out_flags.frame_last;

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+2)'(r_col) < (CW+2)'(r_cols))
        else $error("column counter beyond image width");

    a_block_done_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_s1_valid)
        else $error("completed block did not enter middle stage");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_en) |=> r_out_valid)
        else $error("middle stage word lost on the way out");

    a_frame_implies_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_flags.frame_last || r_out_flags.row_last))
        else $error("frame end without row end");
`endif

endmodule
